/* sv/lde_pkg.sv */
`default_nettype none
package lde_pkg;

  localparam int LINE_DEPTH = 62;
  localparam int PtrW  = $clog2(LINE_DEPTH + 1);
  localparam int AddrW = $clog2(LINE_DEPTH);

  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DC4   = 8'h14;
  localparam logic [7:0] CH_CAN   = 8'h18;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [2:0] {
    KIND_ECHO = 3'd0,
    KIND_LINE = 3'd1,
    KIND_INTR = 3'd2,
    KIND_INFO = 3'd3,
    KIND_EOF  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CFG_ECHO_ENABLE   = 2'd0,
    CFG_LINE_BUFFERED = 2'd1,
    CFG_SIGNAL_GROUP  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_RELEASE
  } state_e;

  typedef struct packed {
    logic [1:0]       pre_cnt;
    kind_e [2:0]      pre_kind;
    logic [2:0][7:0]  pre_val;
    logic [15:0]      pre_grp;
    logic             wr_en;
    logic [7:0]       wr_byte;
    logic [PtrW-1:0]  fill_new;
    logic             rel_en;
  } decode_t;

endpackage
`default_nettype wire

/* sv/lde_decode.sv */
`default_nettype none
module lde_decode (
  input  wire logic [7:0]            byte_i,
  input  wire logic [lde_pkg::PtrW-1:0] fill_i,
  input  wire logic                  echo_en_i,
  input  wire logic                  line_buf_i,
  input  wire logic [15:0]           group_i,
  output lde_pkg::decode_t           dec_o
);
  import lde_pkg::*;

  always_comb begin
    dec_o          = '0;
    dec_o.fill_new = fill_i;
    dec_o.wr_byte  = byte_i;
    if (byte_i == CH_LF || byte_i == CH_CR) begin
      dec_o.wr_en      = 1'b1;
      dec_o.wr_byte    = CH_LF;
      dec_o.fill_new   = fill_i + PtrW'(1);
      dec_o.rel_en     = 1'b1;
      dec_o.pre_cnt    = echo_en_i ? 2'd2 : 2'd0;
      dec_o.pre_val[0] = CH_CR;
      dec_o.pre_val[1] = CH_LF;
    end else if (byte_i == CH_ETX || byte_i == CH_CAN) begin
      dec_o.pre_cnt     = 2'd1;
      dec_o.pre_kind[0] = KIND_INTR;
      dec_o.pre_grp     = group_i;
    end else if (byte_i == CH_DC4) begin
      dec_o.pre_cnt     = 2'd1;
      dec_o.pre_kind[0] = KIND_INFO;
      dec_o.pre_grp     = group_i;
    end else if (byte_i == CH_EOT) begin
      if (fill_i != '0) begin
        dec_o.rel_en = 1'b1;
      end else begin
        dec_o.pre_cnt     = 2'd1;
        dec_o.pre_kind[0] = KIND_EOF;
      end
    end else if (!line_buf_i) begin
      dec_o.wr_en      = 1'b1;
      dec_o.fill_new   = fill_i + PtrW'(1);
      dec_o.rel_en     = 1'b1;
      dec_o.pre_cnt    = echo_en_i ? 2'd2 : 2'd0;
      dec_o.pre_val[0] = CH_CR;
      dec_o.pre_val[1] = CH_LF;
    end else if (byte_i inside {[CH_SPACE:CH_TILDE]}) begin
      if (fill_i < PtrW'(LINE_DEPTH - 1)) begin
        dec_o.wr_en      = 1'b1;
        dec_o.fill_new   = fill_i + PtrW'(1);
        dec_o.pre_cnt    = echo_en_i ? 2'd1 : 2'd0;
        dec_o.pre_val[0] = byte_i;
      end
    end else if (byte_i < CH_SPACE) begin
      dec_o.pre_cnt    = echo_en_i ? 2'd2 : 2'd0;
      dec_o.pre_val[0] = CH_CARET;
      dec_o.pre_val[1] = CH_AT + byte_i;
    end else if (byte_i == CH_DEL) begin
      if (fill_i != '0) begin
        dec_o.fill_new   = fill_i - PtrW'(1);
        dec_o.pre_cnt    = echo_en_i ? 2'd3 : 2'd0;
        dec_o.pre_val[0] = CH_BS;
        dec_o.pre_val[1] = CH_SPACE;
        dec_o.pre_val[2] = CH_BS;
      end
    end else begin
      dec_o.pre_cnt    = echo_en_i ? 2'd1 : 2'd0;
      dec_o.pre_val[0] = CH_QMARK;
    end
  end

endmodule
`default_nettype wire

/* sv/line_discipline_input_editor.sv */
// Results: an echo or event result is loaded into the output register from the registered
// decode once that register is free; a release with no echo first reads the line store
// into a read register, and each line byte moves from there into the output register.
// Throughput: one result per cycle while the output register is not stalled; a release
// emits one result per line byte, up to 62. A new byte is taken once the previous byte's
// last result sits in the output register. Reset clears the fill count, the sequencer and
// the output valid and restores the register defaults; the line store itself is not cleared.
`default_nettype none
module line_discipline_input_editor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [7:0] value, [23:8] target_group
  output logic [2:0]       m_axis_tuser,  // [2:0] kind
  output logic             m_axis_tlast   // last
);
  import lde_pkg::*;

  state_e          state_q, state_d;
  logic [PtrW-1:0] fill_q, fill_d;
  logic [1:0]      pre_idx_q, pre_idx_d;
  logic [PtrW-1:0] iss_q, iss_d;
  logic [PtrW-1:0] cnt_q, cnt_d;
  logic            hold_q, hold_d;
  logic            echo_en_q, line_buf_q;
  logic [15:0]     group_q;

  decode_t         dec, dec_q;
  logic [PtrW-1:0] rel_len_q;
  logic [7:0]      mem [LINE_DEPTH];
  logic [7:0]      rdata_q;

  logic            m_valid_q;
  kind_e           m_kind_q, out_kind;
  logic [7:0]      m_val_q, out_val;
  logic [15:0]     m_grp_q, out_grp;
  logic            m_last_q, out_last;
  logic            out_load, out_free, accept, rd_en, consume, pre_final;

  lde_decode u_decode (
    .byte_i     (s_axis_tdata),
    .fill_i     (fill_q),
    .echo_en_i  (echo_en_q),
    .line_buf_i (line_buf_q),
    .group_i    (group_q),
    .dec_o      (dec)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    pre_idx_d = pre_idx_q;
    iss_d     = iss_q;
    cnt_d     = cnt_q;
    hold_d    = hold_q;
    rd_en     = 1'b0;
    consume   = 1'b0;
    pre_final = 1'b0;
    out_load  = 1'b0;
    out_kind  = KIND_ECHO;
    out_val   = '0;
    out_grp   = '0;
    out_last  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pre_idx_d = '0;
          iss_d     = '0;
          cnt_d     = '0;
          hold_d    = 1'b0;
          fill_d    = dec.rel_en ? '0 : dec.fill_new;
          if (dec.pre_cnt != 2'd0) begin
            state_d = ST_PREFIX;
          end else if (dec.rel_en) begin
            state_d = ST_RELEASE;
          end
        end
      end
      ST_PREFIX: begin
        pre_final = (pre_idx_q == dec_q.pre_cnt - 2'd1);
        if (out_free) begin
          out_load = 1'b1;
          out_kind = dec_q.pre_kind[pre_idx_q];
          out_val  = dec_q.pre_val[pre_idx_q];
          out_grp  = dec_q.pre_grp;
          out_last = pre_final && !dec_q.rel_en;
          if (pre_final) begin
            state_d = dec_q.rel_en ? ST_RELEASE : ST_IDLE;
          end else begin
            pre_idx_d = pre_idx_q + 2'd1;
          end
        end
      end
      ST_RELEASE: begin
        consume = hold_q && out_free;
        rd_en   = (iss_q != rel_len_q) && (!hold_q || consume);
        hold_d  = rd_en || (hold_q && !consume);
        if (rd_en) begin
          iss_d = iss_q + PtrW'(1);
        end
        if (consume) begin
          out_load = 1'b1;
          out_kind = KIND_LINE;
          out_val  = rdata_q;
          out_last = (cnt_q == rel_len_q - PtrW'(1));
          cnt_d    = cnt_q + PtrW'(1);
          if (out_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      pre_idx_q  <= '0;
      iss_q      <= '0;
      cnt_q      <= '0;
      hold_q     <= 1'b0;
      m_valid_q  <= 1'b0;
      echo_en_q  <= 1'b1;
      line_buf_q <= 1'b1;
      group_q    <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      pre_idx_q <= pre_idx_d;
      iss_q     <= iss_d;
      cnt_q     <= cnt_d;
      hold_q    <= hold_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ECHO_ENABLE:   echo_en_q  <= cfg_data_i[0];
          CFG_LINE_BUFFERED: line_buf_q <= cfg_data_i[0];
          CFG_SIGNAL_GROUP:  group_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dec_q     <= dec;
      rel_len_q <= dec.fill_new;
    end
    if (out_load) begin
      m_kind_q <= out_kind;
      m_val_q  <= out_val;
      m_grp_q  <= out_grp;
      m_last_q <= out_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && dec.wr_en) begin
      mem[fill_q[AddrW-1:0]] <= dec.wr_byte;
    end
    if (rd_en) begin
      rdata_q <= mem[iss_q[AddrW-1:0]];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_grp_q, m_val_q};
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

endmodule
`default_nettype wire
